FILE: src/b64d_pkg.sv
// Shared types, constants and the symbol decode function for the base64url decoder.
// No dependencies; used by base64url_strict_decoder_core.
package b64d_pkg;

    // final status codes
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_EXCESS_PAD   = 3'd1,
        ST_DATA_AFTER   = 3'd2,
        ST_BAD_CHAR     = 3'd3,
        ST_BAD_LENGTH   = 3'd4,
        ST_BAD_PADDING  = 3'd5,
        ST_TRAILING     = 3'd6
    } status_t;

    // item command codes
    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_END  = 1'b1
    } cmd_t;

    // result kinds
    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
    localparam logic [5:0] SYM_DASH = 6'd62;
    localparam logic [5:0] SYM_USCORE = 6'd63;
    localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
    localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sym_t;

    // base64url alphabet lookup
    function automatic sym_t sym_decode(input logic [7:0] c);
        sym_t s;
        s.valid = 1'b1;
        s.value = '0;
        if (c inside {[8'h41:8'h5A]}) begin
            s.value = 6'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7A]}) begin
            s.value = 6'(c - 8'h61) + SYM_LOWER_BASE;
        end
        else if (c inside {[8'h30:8'h39]}) begin
            s.value = 6'(c - 8'h30) + SYM_DIGIT_BASE;
        end
        else if (c == 8'h2D) begin
            s.value = SYM_DASH;
        end
        else if (c == 8'h5F) begin
            s.value = SYM_USCORE;
        end
        else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

FILE: src/base64url_strict_decoder_core.sv
// Top level of the strict base64url decoder: decode state and one result register.
// Depends on b64d_pkg (status codes, command codes, symbol decode).

// Takes one beat per clock: a character (cmd 0) or an end-of-message marker (cmd 1).
// Each character is handled in the cycle it is accepted; a character that completes a byte
// yields a data beat, and the marker yields one status beat (last = 1) and clears the
// decoder for the next message. A result reaches the output in the cycle after its input beat.
// Throughput is one beat per cycle; the only stall comes from the single output register,
// so item_ready drops exactly when a result is held and result_ready is low. The first
// character error is latched with its character index (saturating at the all-ones POSITION_BITS value, reported
// saturated to 16 bits); later characters are ignored. A nonzero status means the data
// bytes already delivered for that message must be discarded.
module base64url_strict_decoder_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        cmd,
    input  logic [7:0]  char_code,
    // result channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic        kind,
    output logic [7:0]  data,
    output logic [2:0]  status,
    output logic [15:0] error_position,
    output logic        last
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // decode state
    logic [11:0]              bit_buffer_reg, bit_buffer_next;
    logic [2:0]               bit_count_reg, bit_count_next;
    logic [1:0]               sym_cnt_reg, sym_cnt_next;
    logic [1:0]               pad_count_reg, pad_count_next;
    logic                     pad_seen_reg, pad_seen_next;
    logic                     error_flag_reg, error_flag_next;
    b64d_pkg::status_t        error_code_reg, error_code_next;
    logic [POSITION_BITS-1:0] error_pos_reg, error_pos_next;
    logic [POSITION_BITS-1:0] byte_pos_reg, byte_pos_next;

    // result register
    logic                     result_valid_reg;
    logic                     kind_reg, kind_next;
    logic [7:0]               data_reg, data_next;
    logic [2:0]               status_reg, status_next;
    logic [15:0]              errpos_reg, errpos_next;
    logic                     emit;

    logic                     accept;
    b64d_pkg::sym_t           sym;
    logic [11:0]              shifted_buf;
    logic [3:0]               bit_sum;
    logic [3:0]               out_shift;
    logic [11:0]              aligned;
    logic [1:0]               pad_need;
    logic [6:0]               tail_mask;
    logic [15:0]              pos_report;

    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    // saturate the latched position to the 16-bit report
    generate
        if (POSITION_BITS > 16) begin : g_pos_wide
            assign pos_report = (|error_pos_reg[POSITION_BITS-1:16]) ? 16'hFFFF
                                                                   : error_pos_reg[15:0];
        end
        else begin : g_pos_narrow
            assign pos_report = 16'(error_pos_reg);
        end
    endgenerate

    // symbol datapath helpers
    assign sym         = b64d_pkg::sym_decode(char_code);
    assign shifted_buf = {bit_buffer_reg[5:0], sym.value};
    assign bit_sum     = {1'b0, bit_count_reg} + 4'd6;
    assign out_shift   = bit_sum - 4'd8;
    assign aligned     = shifted_buf >> out_shift;
    assign pad_need    = 2'd0 - sym_cnt_reg;
    assign tail_mask   = (7'd1 << bit_count_reg) - 7'd1;

    // next state and result
    always_comb
    begin
        bit_buffer_next = bit_buffer_reg;
        bit_count_next  = bit_count_reg;
        sym_cnt_next    = sym_cnt_reg;
        pad_count_next  = pad_count_reg;
        pad_seen_next   = pad_seen_reg;
        error_flag_next = error_flag_reg;
        error_code_next = error_code_reg;
        error_pos_next  = error_pos_reg;
        byte_pos_next   = byte_pos_reg;
        emit            = 1'b0;
        kind_next       = b64d_pkg::KIND_DATA;
        data_next       = '0;
        status_next     = b64d_pkg::ST_OK;
        errpos_next     = '0;

        if (cmd == b64d_pkg::CMD_END) begin
            // end of message: final checks, then clear everything
            emit      = 1'b1;
            kind_next = b64d_pkg::KIND_STATUS;
            if (error_flag_reg) begin
                status_next = error_code_reg;
                errpos_next = pos_report;
            end
            else if (sym_cnt_reg == 2'd1) begin
                status_next = b64d_pkg::ST_BAD_LENGTH;
            end
            else if (pad_count_reg != 2'd0 &&
                     (pad_need == 2'd0 || pad_count_reg != pad_need)) begin
                status_next = b64d_pkg::ST_BAD_PADDING;
            end
            else if ((bit_buffer_reg[6:0] & tail_mask) != 7'd0) begin
                status_next = b64d_pkg::ST_TRAILING;
            end
            bit_buffer_next = '0;
            bit_count_next  = '0;
            sym_cnt_next    = '0;
            pad_count_next  = '0;
            pad_seen_next   = 1'b0;
            error_flag_next = 1'b0;
            error_code_next = b64d_pkg::ST_OK;
            error_pos_next  = '0;
            byte_pos_next   = '0;
        end
        else begin
            if (!error_flag_reg) begin
                if (char_code == b64d_pkg::PAD_CHAR) begin
                    pad_seen_next = 1'b1;
                    if (pad_count_reg >= 2'd2) begin
                        pad_count_next  = 2'd3;
                        error_flag_next = 1'b1;
                        error_code_next = b64d_pkg::ST_EXCESS_PAD;
                        error_pos_next  = byte_pos_reg;
                    end
                    else begin
                        pad_count_next = pad_count_reg + 2'd1;
                    end
                end
                else if (pad_seen_reg) begin
                    error_flag_next = 1'b1;
                    error_code_next = b64d_pkg::ST_DATA_AFTER;
                    error_pos_next  = byte_pos_reg;
                end
                else if (!sym.valid) begin
                    error_flag_next = 1'b1;
                    error_code_next = b64d_pkg::ST_BAD_CHAR;
                    error_pos_next  = byte_pos_reg;
                end
                else begin
                    bit_buffer_next = shifted_buf;
                    sym_cnt_next    = sym_cnt_reg + 2'd1;
                    if (bit_sum >= 4'd8) begin
                        bit_count_next = out_shift[2:0];
                        emit           = 1'b1;
                        data_next      = aligned[7:0];
                    end
                    else begin
                        bit_count_next = bit_sum[2:0];
                    end
                end
            end
            // character index keeps counting, even after an error
            if (byte_pos_reg != POS_MAX) begin
                byte_pos_next = byte_pos_reg + 1'b1;
            end
        end
    end

    // decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bit_buffer_reg <= '0;
            bit_count_reg  <= '0;
            sym_cnt_reg    <= '0;
            pad_count_reg  <= '0;
            pad_seen_reg   <= 1'b0;
            error_flag_reg <= 1'b0;
            error_code_reg <= b64d_pkg::ST_OK;
            error_pos_reg  <= '0;
            byte_pos_reg   <= '0;
        end
        else if (accept) begin
            bit_buffer_reg <= bit_buffer_next;
            bit_count_reg  <= bit_count_next;
            sym_cnt_reg    <= sym_cnt_next;
            pad_count_reg  <= pad_count_next;
            pad_seen_reg   <= pad_seen_next;
            error_flag_reg <= error_flag_next;
            error_code_reg <= error_code_next;
            error_pos_reg  <= error_pos_next;
            byte_pos_reg   <= byte_pos_next;
        end
    end

    // result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end
        else if (accept && emit) begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready) begin
            result_valid_reg <= 1'b0;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (accept && emit) begin
            kind_reg   <= kind_next;
            data_reg   <= data_next;
            status_reg <= status_next;
            errpos_reg <= errpos_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign kind           = kind_reg;
    assign data           = data_reg;
    assign status         = status_reg;
    assign error_position = errpos_reg;
    assign last           = kind_reg;

    // a data beat carries no status and no position
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == b64d_pkg::KIND_DATA |->
            status == b64d_pkg::ST_OK && error_position == 16'd0)
        else $error("data beat with status or position set");

    // end marker clears the decoder
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == b64d_pkg::CMD_END |=>
            bit_count_reg == 3'd0 && !error_flag_reg && !pad_seen_reg && byte_pos_reg == '0)
        else $error("decoder state not cleared after end marker");

    // a latched error holds until the end marker
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_flag_reg && !(accept && cmd == b64d_pkg::CMD_END) |=>
            error_flag_reg && $stable(error_code_reg) && $stable(error_pos_reg))
        else $error("latched error changed mid-message");

    // pending bit count is always even
    a_bits_even: assert property (@(posedge clk) disable iff (!rst_n)
        !bit_count_reg[0] && bit_count_reg != 3'd7)
        else $error("odd pending bit count");

endmodule

FILE: sim/base64url_strict_decoder_core_test.sv
// Self-checking testbench for base64url_strict_decoder_core: random and directed messages.
// Depends on b64d_pkg (command, kind and status codes) and the decoder RTL under src.
`timescale 1ns / 1ps

module base64url_strict_decoder_core_test;

    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam int TARGET_ITEMS = 1550;
    localparam int HOLD_CYCLES = 240;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_RUN = 41;
    localparam int REPORT_MAX = 10;

    // stimulus queue entries: a real beat or a control mark for the driver
    typedef enum logic [1:0] {
        MK_ITEM,
        MK_HOLD,
        MK_DRAIN,
        MK_QUIET
    } mark_t;

    typedef struct {
        mark_t            mark;
        b64d_pkg::cmd_t   op;
        logic [7:0]       code;
    } char_beat_t;

    typedef struct {
        b64d_pkg::kind_t   kind;
        logic [7:0]        data;
        b64d_pkg::status_t status;
        logic [15:0]       pos;
        logic              last;
    } decoded_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic        cmd = 1'b0;
    logic [7:0]  char_code = 8'h00;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [15:0] error_position;
    logic        last;

    // driver and monitor control
    char_beat_t    pending [$];
    decoded_beat_t decoded_due [$];
    logic          quiet = 1'b0;
    logic          hold_kick = 1'b0;
    logic          tx_done = 1'b0;
    int            tx_gap = 0;
    int            rx_gap = 0;
    int            rx_hold_left = 0;
    int            planned = 0;
    int            cycles = 0;

    // tallies
    int fail_count = 0;
    int chars_fed = 0;
    int msgs_fed = 0;
    int data_seen = 0;
    int status_seen = 0;
    int st_seen [0:7];

    // predictor state
    logic [11:0]         acc_bits;
    logic [2:0]          acc_cnt;
    logic [1:0]          grp_phase;
    logic [1:0]          pad_run;
    logic                pad_hit;
    logic                err_hit;
    b64d_pkg::status_t   err_code;
    logic [15:0]         err_at;
    logic [POS_BITS-1:0] char_idx;

    base64url_strict_decoder_core #(
        .POSITION_BITS(POS_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .cmd            (cmd),
        .char_code      (char_code),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .kind           (kind),
        .data           (data),
        .status         (status),
        .error_position (error_position),
        .last           (last)
    );

    always #5 clk = ~clk;

    // 6-bit value of an alphabet character, -1 when outside the alphabet
    function automatic int sextet_of(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z")
            return int'(ch) - int'("A");
        if (ch >= "a" && ch <= "z")
            return int'(ch) - int'("a") + 26;
        if (ch >= "0" && ch <= "9")
            return int'(ch) - int'("0") + 52;
        if (ch == "-")
            return 62;
        if (ch == "_")
            return 63;
        return -1;
    endfunction

    // alphabet character for a 6-bit value (stimulus side)
    function automatic logic [7:0] symbol_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'("A") + 8'(v);
        if (v < 6'd52)
            return 8'("a") + 8'(v - 6'd26);
        if (v < 6'd62)
            return 8'("0") + 8'(v - 6'd52);
        if (v == 6'd62)
            return 8'("-");
        return 8'("_");
    endfunction

    task automatic clear_decoder();
        acc_bits = '0;
        acc_cnt = '0;
        grp_phase = '0;
        pad_run = '0;
        pad_hit = 1'b0;
        err_hit = 1'b0;
        err_code = b64d_pkg::ST_OK;
        err_at = '0;
        char_idx = '0;
    endtask

    task automatic latch_error(input b64d_pkg::status_t code);
        err_hit = 1'b1;
        err_code = code;
        err_at = (char_idx > POS_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(char_idx);
    endtask

    // advance the decoder model by one accepted beat, queue what it emits
    task automatic decode_predict(input b64d_pkg::cmd_t op, input logic [7:0] ch);
        decoded_beat_t b;
        logic [1:0]    fill;
        logic [3:0]    cnt;
        logic [11:0]   mask;
        int            v;
        b.kind = b64d_pkg::KIND_DATA;
        b.data = '0;
        b.status = b64d_pkg::ST_OK;
        b.pos = '0;
        b.last = 1'b0;
        if (op == b64d_pkg::CMD_END) begin
            // end-of-message checks, first match wins
            fill = 2'd0 - grp_phase;
            mask = (12'd1 << acc_cnt) - 12'd1;
            b.kind = b64d_pkg::KIND_STATUS;
            b.last = 1'b1;
            if (err_hit) begin
                b.status = err_code;
                b.pos = err_at;
            end
            else if (grp_phase == 2'd1)
                b.status = b64d_pkg::ST_BAD_LENGTH;
            else if (pad_run != 2'd0 && (fill == 2'd0 || pad_run != fill))
                b.status = b64d_pkg::ST_BAD_PADDING;
            else if ((acc_bits & mask) != 12'd0)
                b.status = b64d_pkg::ST_TRAILING;
            decoded_due.insert(decoded_due.size(), b);
            clear_decoder();
        end
        else begin
            if (!err_hit) begin
                if (ch == b64d_pkg::PAD_CHAR) begin
                    pad_hit = 1'b1;
                    if (pad_run >= 2'd2) begin
                        pad_run = 2'd3;
                        latch_error(b64d_pkg::ST_EXCESS_PAD);
                    end
                    else
                        pad_run = pad_run + 2'd1;
                end
                else if (pad_hit)
                    latch_error(b64d_pkg::ST_DATA_AFTER);
                else begin
                    v = sextet_of(ch);
                    if (v < 0)
                        latch_error(b64d_pkg::ST_BAD_CHAR);
                    else begin
                        acc_bits = {acc_bits[5:0], 6'(v)};
                        cnt = {1'b0, acc_cnt} + 4'd6;
                        grp_phase = grp_phase + 2'd1;
                        if (cnt >= 4'd8) begin
                            cnt = cnt - 4'd8;
                            b.data = 8'(acc_bits >> cnt);
                            decoded_due.insert(decoded_due.size(), b);
                        end
                        acc_cnt = cnt[2:0];
                    end
                end
            end
            // index keeps counting even after an error, saturating
            if (char_idx != POS_MAX)
                char_idx = char_idx + 1'b1;
        end
    endtask

    task automatic push_item(input b64d_pkg::cmd_t op, input logic [7:0] ch);
        char_beat_t e;
        e.mark = MK_ITEM;
        e.op = op;
        e.code = ch;
        pending.insert(pending.size(), e);
        planned++;
    endtask

    task automatic push_mark(input mark_t m);
        char_beat_t e;
        e.mark = m;
        e.op = b64d_pkg::CMD_CHAR;
        e.code = 8'h00;
        pending.insert(pending.size(), e);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(b64d_pkg::CMD_CHAR, 8'(s[i]));
    endtask

    // receiver long hold-off, kicked by the driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rx_hold_left <= 0;
        else if (hold_kick)
            rx_hold_left <= HOLD_CYCLES;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // driver: offers queued beats, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin : drive
        logic       busy;
        logic       valid_n;
        logic       kick_n;
        char_beat_t nxt;
        if (!rst_n) begin
            item_valid <= 1'b0;
            cmd <= b64d_pkg::CMD_CHAR;
            char_code <= 8'h00;
            hold_kick <= 1'b0;
            quiet <= 1'b0;
            tx_gap <= 0;
            tx_done <= 1'b0;
        end
        else begin
            busy = item_valid;
            kick_n = 1'b0;
            if (item_valid && item_ready) begin
                decode_predict(b64d_pkg::cmd_t'(cmd), char_code);
                if (cmd == b64d_pkg::CMD_END)
                    msgs_fed++;
                else
                    chars_fed++;
                busy = 1'b0;
            end
            valid_n = busy;
            if (!busy) begin
                if (pending.size() != 0 && pending[0].mark == MK_HOLD) begin
                    kick_n = 1'b1;
                    void'(pending.pop_front());
                end
                else if (pending.size() != 0 && pending[0].mark == MK_QUIET) begin
                    quiet <= 1'b1;
                    void'(pending.pop_front());
                end
                else if (pending.size() != 0 && pending[0].mark == MK_DRAIN) begin
                    // sender pauses until every outstanding beat is back
                    if (decoded_due.size() == 0)
                        void'(pending.pop_front());
                end
                else if (tx_gap != 0)
                    tx_gap <= tx_gap - 1;
                else if (!quiet && $urandom_range(0, 5) == 0)
                    tx_gap <= $urandom_range(0, 10);
                else if (pending.size() != 0) begin
                    nxt = pending.pop_front();
                    valid_n = 1'b1;
                    cmd <= nxt.op;
                    char_code <= nxt.code;
                end
            end
            item_valid <= valid_n;
            hold_kick <= kick_n;
            tx_done <= (pending.size() == 0) && !valid_n;
        end
    end

    // monitor: checks each result beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch
        decoded_beat_t want;
        if (!rst_n) begin
            result_ready <= 1'b0;
            rx_gap <= 0;
        end
        else begin
            if (result_valid && result_ready) begin
                if (kind == b64d_pkg::KIND_STATUS) begin
                    status_seen++;
                    st_seen[status]++;
                end
                else
                    data_seen++;
                if (decoded_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected beat: kind=%0d data=%02h status=%0d pos=%0d",
                                 kind, data, status, error_position);
                end
                else begin
                    want = decoded_due.pop_front();
                    if (kind !== want.kind || data !== want.data || status !== want.status ||
                        error_position !== want.pos || last !== want.last) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $display("mismatch: expected kind=%0d data=%02h status=%0d pos=%0d last=%0d",
                                     want.kind, want.data, want.status, want.pos, want.last);
                            $display("          got      kind=%0d data=%02h status=%0d pos=%0d last=%0d",
                                     kind, data, status, error_position, last);
                        end
                    end
                end
            end
            // ready pattern: long hold, random bursts, or always on near the end
            if (rx_hold_left != 0)
                result_ready <= 1'b0;
            else if (rx_gap != 0) begin
                rx_gap <= rx_gap - 1;
                result_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0) begin
                rx_gap <= $urandom_range(0, 10);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // run limit
    initial
    begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("base64url_strict_decoder_core_test: errors");
        $finish;
    end

    // stimulus plan, reset and end of run
    initial
    begin
        logic [7:0]  raw [$];
        logic [7:0]  txt [$];
        logic [23:0] grp;
        int          nbytes;
        int          tail;
        int          sel;
        int          idx;
        int          n;
        bit          hold_done;
        bit          drain_done;
        hold_done = 0;
        drain_done = 0;
        foreach (st_seen[i])
            st_seen[i] = 0;
        clear_decoder();

        // directed: empty, ok with pad, each error kind, trailing bits
        push_item(b64d_pkg::CMD_END, 8'h00);
        push_text("AQ==");
        push_item(b64d_pkg::CMD_END, 8'h00);
        push_text("A");
        push_item(b64d_pkg::CMD_END, 8'h00);
        push_text("A===");
        push_item(b64d_pkg::CMD_END, 8'h00);
        push_text("AB=C");
        push_item(b64d_pkg::CMD_CHAR, 8'hFF);
        push_item(b64d_pkg::CMD_END, 8'h00);
        push_text("A");
        push_item(b64d_pkg::CMD_CHAR, 8'h00);
        push_item(b64d_pkg::CMD_END, 8'h00);
        push_text("AAAA=");
        push_item(b64d_pkg::CMD_END, 8'h00);
        push_text("-_");
        push_item(b64d_pkg::CMD_END, 8'h00);
        push_mark(MK_DRAIN);

        // random messages, mostly well-formed encodings of random bytes
        while (planned < TARGET_ITEMS) begin
            if (!hold_done && planned >= 500) begin
                push_mark(MK_HOLD);
                hold_done = 1;
            end
            if (!drain_done && planned >= 700) begin
                push_mark(MK_DRAIN);
                drain_done = 1;
            end
            raw.delete();
            txt.delete();
            nbytes = $urandom_range(0, 12);
            for (int i = 0; i < nbytes; i++)
                raw.insert(raw.size(), 8'($urandom_range(0, 255)));
            raw.insert(raw.size(), 8'h00);
            raw.insert(raw.size(), 8'h00);
            for (int i = 0; i < nbytes; i += 3) begin
                tail = nbytes - i;
                grp = {raw[i], raw[i+1], raw[i+2]};
                txt.insert(txt.size(), symbol_char(grp[23:18]));
                txt.insert(txt.size(), symbol_char(grp[17:12]));
                if (tail > 1)
                    txt.insert(txt.size(), symbol_char(grp[11:6]));
                if (tail > 2)
                    txt.insert(txt.size(), symbol_char(grp[5:0]));
            end
            if ($urandom_range(0, 1) == 1)
                repeat ((4 - txt.size() % 4) % 4)
                    txt.insert(txt.size(), b64d_pkg::PAD_CHAR);
            // damage some of them
            sel = $urandom_range(0, 9);
            if (sel == 6) begin
                if (txt.size() == 0)
                    txt.insert(txt.size(), 8'($urandom_range(0, 255)));
                else begin
                    idx = $urandom_range(0, txt.size() - 1);
                    txt[idx] = 8'($urandom_range(0, 255));
                end
            end
            else if (sel == 7) begin
                if (txt.size() != 0 && $urandom_range(0, 1) == 1)
                    void'(txt.pop_back());
                else
                    repeat ($urandom_range(1, 3))
                        txt.insert(txt.size(), b64d_pkg::PAD_CHAR);
            end
            else if (sel == 8) begin
                txt.delete();
                repeat ($urandom_range(1, 9))
                    txt.insert(txt.size(), symbol_char(6'($urandom_range(0, 63))));
                repeat ($urandom_range(0, 3))
                    txt.insert(txt.size(), b64d_pkg::PAD_CHAR);
            end
            else if (sel == 9) begin
                txt.delete();
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 2))
                        0: txt.insert(txt.size(), b64d_pkg::PAD_CHAR);
                        1: txt.insert(txt.size(), symbol_char(6'($urandom_range(0, 63))));
                        default: txt.insert(txt.size(), 8'($urandom_range(0, 255)));
                    endcase
                end
            end
            foreach (txt[i])
                push_item(b64d_pkg::CMD_CHAR, txt[i]);
            push_item(b64d_pkg::CMD_END, 8'h00);
        end

        // last part without idling: a long unpadded run, then a bad character
        push_mark(MK_DRAIN);
        push_mark(MK_QUIET);
        repeat (LONG_RUN)
            push_item(b64d_pkg::CMD_CHAR, 8'("A"));
        push_item(b64d_pkg::CMD_CHAR, 8'hFF);
        push_text("AB");
        push_item(b64d_pkg::CMD_END, 8'h00);
        push_text("AQ==");
        push_item(b64d_pkg::CMD_END, 8'h00);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (!(tx_done && decoded_due.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (decoded_due.size() != 0) begin
            fail_count++;
            $display("%0d predicted beats never arrived", decoded_due.size());
        end

        $display("covered %0d messages, %0d characters; %0d data bytes, %0d status beats",
                 msgs_fed, chars_fed, data_seen, status_seen);
        $display("statuses ok/excess/after-pad/char/length/pad/trailing: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4], st_seen[5],
                 st_seen[6]);
        if (fail_count == 0)
            $display("base64url_strict_decoder_core_test: clean");
        else
            $display("base64url_strict_decoder_core_test: errors");
        $finish;
    end

endmodule
